### sv/pba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg: shared types and codes for the page bitmap allocator
// Holds the command and result structs, the command kinds, status codes and config register indices.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_NULL      = 3'd2;
  localparam logic [2:0] ST_TOO_FEW   = 3'd3;
  localparam logic [2:0] ST_NO_RUN    = 3'd4;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd5;

  localparam logic [2:0] REG_RAM_BASE     = 3'd0;
  localparam logic [2:0] REG_TOTAL_PAGES  = 3'd1;
  localparam logic [2:0] REG_KERNEL_FIRST = 3'd2;
  localparam logic [2:0] REG_KERNEL_END   = 3'd3;
  localparam logic [2:0] REG_TABLE_FIRST  = 3'd4;
  localparam logic [2:0] REG_TABLE_END    = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] count;
    logic [63:0] address;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] run_address;
    logic [12:0] free_count;
  } rsp_t;

endpackage
`default_nettype wire

### sv/page_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator: first-fit bitmap page allocator
// Keeps one used bit per page in a memory and walks it page by page.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  command | start_i, busy_o, cmd_i           | in, taken when start_i & !busy_o
//  result  | done_o, rsp_o                    | out, one-cycle strobe
//  config  | cfg_valid_i, cfg_ready_o,        | in, taken when valid & ready
//          | cfg_index_i, cfg_data_i          |
// Sequence: after reset a clearing pass marks all MaxPages pages used, with
// commands held off. Init rewrites every page of the map. Alloc walks the map
// one page per cycle up to the end of the run found and then writes the run
// back one page per cycle. Free reads each page and then writes it back. The
// map memory has separate write and read ports. The result strobe cannot be
// stalled.
// ----------------------------------------------------------------------------
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int unsigned MaxPages  = 4096,
  parameter int unsigned PageBytes = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire cmd_t        cmd_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxPages);
  localparam int unsigned PW = $clog2(MaxPages + 1);
  localparam int unsigned SH = $clog2(PageBytes);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [PW-1:0] MAX_P = PW'(MaxPages);

  logic [2:0]  state_q, state_d;
  logic [63:0] ram_base_q;
  logic [12:0] total_q, kf_q, ke_q, tf_q, te_q;
  logic [PW-1:0] active_q, active_d;
  logic [PW-1:0] free_q, free_d;
  logic        ready_q, ready_d;
  logic [PW:0] idx_q, idx_d;        // current page, one spare bit
  logic [PW:0] rstart_q, rstart_d;  // run start
  logic [13:0] run_q, run_d;
  logic        rvalid_q, rvalid_d;  // read data is valid (for idx_q-1 in scan, for idx_q in free)
  logic [12:0] cnt_q, cnt_d;
  logic [2:0]  st_q, st_d;
  logic [63:0] raddr_q, raddr_d;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic        wdata, rbit;
  logic [PW:0] cur;
  logic        resv;
  logic [63:0] offset;
  logic [63:0] limit;

  pba_map_ram #(.Depth(MaxPages), .AddrW(AW)) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rbit)
  );

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q <= '0;
      total_q <= '0; kf_q <= '0; ke_q <= '0; tf_q <= '0; te_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RAM_BASE:     ram_base_q <= cfg_data_i;
        REG_TOTAL_PAGES:  total_q <= cfg_data_i[12:0];
        REG_KERNEL_FIRST: kf_q <= cfg_data_i[12:0];
        REG_KERNEL_END:   ke_q <= cfg_data_i[12:0];
        REG_TABLE_FIRST:  tf_q <= cfg_data_i[12:0];
        REG_TABLE_END:    te_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // reserved page test for init, address offset and limit for free
  always_comb begin
    cur  = idx_q;
    resv = ({{(32-PW-1){1'b0}}, idx_q} >= {19'd0, kf_q} &&
            {{(32-PW-1){1'b0}}, idx_q} <  {19'd0, ke_q}) ||
           ({{(32-PW-1){1'b0}}, idx_q} >= {19'd0, tf_q} &&
            {{(32-PW-1){1'b0}}, idx_q} <  {19'd0, te_q});
    offset = cmd_i.address - ram_base_q;
    limit  = {{(64-PW){1'b0}}, active_q} << SH;
  end

  // sequencer
  always_comb begin
    state_d = state_q; active_d = active_q; free_d = free_q; ready_d = ready_q;
    idx_d = idx_q; rstart_d = rstart_q; run_d = run_q; rvalid_d = 1'b0;
    cnt_d = cnt_q; st_d = st_q; raddr_d = raddr_q;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = 1'b1; raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == {1'b0, MAX_P} - 1'b1) state_d = S_IDLE;
      end
      S_IDLE: begin
        idx_d = '0; run_d = '0; cnt_d = cmd_i.count; raddr_d = '0; st_d = ST_OK;
        if (start_i) begin
          state_d = S_DONE;
          unique case (cmd_i.kind)
            KIND_INIT: begin
              free_d = '0;
              active_d = ({19'd0, total_q} > 32'(MaxPages)) ? MAX_P
                                                            : PW'(total_q);
              ready_d = 1'b0;
              st_d = (total_q == 13'd0) ? ST_NOT_READY : ST_OK;
              state_d = S_INIT;
            end
            KIND_ALLOC: begin
              if (cmd_i.count == 13'd0) st_d = ST_NULL;
              else if (!ready_q) st_d = ST_NOT_READY;
              else if ({{(32-PW){1'b0}}, free_q} < {19'd0, cmd_i.count})
                st_d = ST_TOO_FEW;
              else state_d = S_SCAN;
            end
            KIND_FREE: begin
              if (cmd_i.count == 13'd0 || cmd_i.address == 64'd0) st_d = ST_NULL;
              else if (!ready_q) st_d = ST_NOT_READY;
              else if (cmd_i.address < ram_base_q || offset >= limit ||
                       cmd_i.address[SH-1:0] != '0) st_d = ST_BAD_ADDR;
              else begin
                idx_d = {1'b0, offset[SH+PW-1:SH]};
                state_d = S_FREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        // mark every page used, free those managed and not reserved
        we = 1'b1;
        wdata = !({1'b0, active_q} > idx_q && !resv);
        if (!wdata) free_d = free_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == {1'b0, MAX_P} - 1'b1) begin
          ready_d = (active_q != '0);
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        // issue read of idx_q, evaluate bit of idx_q-1
        if (idx_q < {1'b0, active_q}) begin
          idx_d = idx_q + 1'b1;
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          if (rbit) run_d = '0;
          else begin
            if (run_q == '0) rstart_d = cur - 1'b1;
            run_d = run_q + 1'b1;
            if (run_q + 1'b1 == {1'b0, cnt_q}) begin
              idx_d = (run_q == '0) ? cur - 1'b1 : rstart_q;
              raddr_d = ram_base_q + ({{(63-PW){1'b0}}, idx_d} << SH);
              rvalid_d = 1'b0;
              free_d = free_q - PW'(cnt_q);
              state_d = S_MARK;
            end
          end
        end
        if (state_d == S_SCAN && !rvalid_d) begin
          if (!(idx_q < {1'b0, active_q}) && !rvalid_q) begin
            st_d = ST_NO_RUN;
            state_d = S_DONE;
          end
        end
      end
      S_MARK: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 13'd1) state_d = S_DONE;
      end
      S_FREE: begin
        // read-modify-write per page: read the bit, then write it back clear
        if (!rvalid_q) begin
          if (cnt_q == 13'd0 || idx_q >= {1'b0, active_q}) state_d = S_DONE;
          else rvalid_d = 1'b1;
        end else begin
          we = 1'b1; wdata = 1'b0;
          if (rbit) free_d = free_q + 1'b1;
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; active_q <= '0; free_q <= '0; ready_q <= 1'b0;
      idx_q <= '0; rstart_q <= '0; run_q <= '0; rvalid_q <= 1'b0;
      cnt_q <= '0; st_q <= ST_OK; raddr_q <= '0;
    end else begin
      state_q <= state_d; active_q <= active_d; free_q <= free_d;
      ready_q <= ready_d; idx_q <= idx_d; rstart_q <= rstart_d; run_q <= run_d;
      rvalid_q <= rvalid_d; cnt_q <= cnt_d; st_q <= st_d; raddr_q <= raddr_d;
    end
  end

  // result
  assign done_o = (state_q == S_DONE);
  always_comb begin
    rsp_o.status      = st_q;
    rsp_o.run_address = raddr_q;
    rsp_o.free_count  = ready_q ? 13'(free_q) : 13'd0;
  end

  // checks
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_free_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= MAX_P) else $error("free count above map size");
  a_notready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ready_q) |-> rsp_o.free_count == 13'd0)
    else $error("free count shown while not ready");
  a_runaddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> rsp_o.run_address == 64'd0)
    else $error("run address on failed item");

endmodule
`default_nettype wire

### sv/pba_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_map_ram: page used-map storage
// One bit per page, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pba_map_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic             wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic                  rdata_o
);

  logic mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### verif/tb_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator: self-checking bench for the page bitmap allocator
// Runs configuration phases, from reset defaults and extremes to random
// settings. In each phase a queue of init, alloc and free commands is driven
// through the start/busy handshake. A bit-level page map in the bench predicts
// every result, and the monitor compares each result strobe with that
// prediction.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  localparam int unsigned NUM_PAGES  = 4096;
  localparam int unsigned PG_BYTES   = 4096;
  localparam logic [1:0]  KIND_NONE  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = REG_RAM_BASE;
  logic [63:0] cfg_data_i = '0;
  logic        busy_o, done_o, cfg_ready_o;
  rsp_t        rsp_o;

  page_bitmap_allocator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Page map copy and register shadow
  bit          page_used [NUM_PAGES];
  int unsigned free_cnt;
  bit          map_ready;
  int unsigned active_pages;
  logic [63:0] base_addr;
  logic [12:0] total_reg, kern_lo, kern_hi, tbl_lo, tbl_hi;

  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   gap_pct = 0;
  int   errors = 0;
  int   cmds_taken = 0;
  int   rsps_seen = 0;
  int   phases = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit reserved(int unsigned p);
    return (p >= kern_lo && p < kern_hi) || (p >= tbl_lo && p < tbl_hi);
  endfunction

  // Apply one command to the page map and return the response it produces
  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t r;
    int unsigned run_len, run_start;
    logic [63:0] off;
    longint unsigned pg;
    r = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_INIT: begin
        for (int i = 0; i < NUM_PAGES; i++) page_used[i] = 1'b1;
        free_cnt = 0;
        active_pages = (total_reg > NUM_PAGES) ? NUM_PAGES : total_reg;
        if (active_pages == 0) begin
          map_ready = 1'b0;
          r.status = ST_NOT_READY;
        end else begin
          for (int unsigned i = 0; i < active_pages; i++) begin
            if (!reserved(i)) begin
              page_used[i] = 1'b0;
              free_cnt++;
            end
          end
          map_ready = 1'b1;
        end
      end
      KIND_ALLOC: begin
        if (c.count == 0) r.status = ST_NULL;
        else if (!map_ready) r.status = ST_NOT_READY;
        else if (free_cnt < c.count) r.status = ST_TOO_FEW;
        else begin
          r.status = ST_NO_RUN;
          run_len = 0;
          run_start = 0;
          for (int unsigned i = 0; i < active_pages; i++) begin
            if (page_used[i]) begin
              run_len = 0;
            end else begin
              if (run_len == 0) run_start = i;
              run_len++;
              if (run_len == c.count) begin
                for (int unsigned k = run_start; k <= i; k++) page_used[k] = 1'b1;
                free_cnt -= c.count;
                r.run_address = base_addr + 64'(run_start) * 64'(PG_BYTES);
                r.status = ST_OK;
                break;
              end
            end
          end
        end
      end
      KIND_FREE: begin
        if (c.count == 0 || c.address == 0) r.status = ST_NULL;
        else if (!map_ready) r.status = ST_NOT_READY;
        else if (c.address < base_addr) r.status = ST_BAD_ADDR;
        else begin
          off = c.address - base_addr;
          if (off >= 64'(active_pages) * 64'(PG_BYTES)) r.status = ST_BAD_ADDR;
          else if (c.address % PG_BYTES != 0) r.status = ST_BAD_ADDR;
          else begin
            pg = off / PG_BYTES;
            for (int unsigned i = 0; i < c.count; i++) begin
              if (pg + i >= active_pages) break;
              if (page_used[pg + i]) begin
                page_used[pg + i] = 1'b0;
                free_cnt++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.free_count = map_ready ? 13'(free_cnt) : 13'd0;
    return r;
  endfunction

  // Driver: hold start until the transaction is taken, then pull the next one
  bit   drv_start;
  cmd_t drv_cmd;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_start = start_i;
      drv_cmd = cmd_i;
      if (start_i && !busy_o) begin
        expected_rsps.push_back(apply_cmd(cmd_i));
        cmds_taken++;
        drv_start = 1'b0;
      end
      if (!drv_start && pending_cmds.size() > 0 && $urandom_range(99) >= gap_pct) begin
        drv_start = 1'b1;
        drv_cmd = pending_cmds.pop_front();
      end
      start_i <= drv_start;
      cmd_i <= drv_cmd;
    end
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
             what, got, want, rsps_seen, $time);
  endtask

  // Monitor: check each result strobe against the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result, status", rsp_o.status, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", rsp_o.status, want.status);
        if (rsp_o.run_address !== want.run_address)
          report_mismatch("run_address", rsp_o.run_address, want.run_address);
        if (rsp_o.free_count !== want.free_count)
          report_mismatch("free_count", rsp_o.free_count, want.free_count);
      end
      rsps_seen++;
    end
  end

  function automatic void push_cmd(logic [1:0] k, logic [12:0] n, logic [63:0] a);
    cmd_t c;
    c.kind = k;
    c.count = n;
    c.address = a;
    pending_cmds.push_back(c);
  endfunction

  // Address of a page under the settings now in force
  function automatic logic [63:0] page_addr(int unsigned p);
    return base_addr + 64'(p) * 64'(PG_BYTES);
  endfunction

  // Write all six registers back to back; valid stays high between them
  task automatic program_regs(logic [63:0] base, logic [12:0] tot, logic [12:0] klo,
                              logic [12:0] khi, logic [12:0] tlo, logic [12:0] thi);
    logic [63:0] vals [6];
    logic [2:0]  idx  [6];
    vals = '{base, 64'(tot), 64'(klo), 64'(khi), 64'(tlo), 64'(thi)};
    idx = '{REG_RAM_BASE, REG_TOTAL_PAGES, REG_KERNEL_FIRST, REG_KERNEL_END,
            REG_TABLE_FIRST, REG_TABLE_END};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        REG_RAM_BASE:     base_addr = vals[i];
        REG_TOTAL_PAGES:  total_reg = vals[i][12:0];
        REG_KERNEL_FIRST: kern_lo = vals[i][12:0];
        REG_KERNEL_END:   kern_hi = vals[i][12:0];
        REG_TABLE_FIRST:  tbl_lo = vals[i][12:0];
        default:          tbl_hi = vals[i][12:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Drain the command queue and all results, then let the block settle
  task automatic drain();
    while (pending_cmds.size() > 0 || start_i || expected_rsps.size() > 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random commands: mostly small allocs and frees of valid runs, some noise
  task automatic random_cmds(int n, int unsigned max_cnt);
    int unsigned span, r;
    span = (active_pages == 0) ? 1 : active_pages;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) push_cmd(KIND_INIT, 13'($urandom), 64'($urandom));
      else if (r < 45) push_cmd(KIND_ALLOC, 13'($urandom_range(max_cnt, 1)), {$urandom, $urandom});
      else if (r < 85)
        push_cmd(KIND_FREE, 13'($urandom_range(max_cnt, 1)), page_addr($urandom_range(span - 1)));
      else if (r < 89) push_cmd(KIND_ALLOC, 13'($urandom), {$urandom, $urandom});
      else if (r < 93) push_cmd(KIND_FREE, 13'($urandom), {$urandom, $urandom});
      else if (r < 96)
        push_cmd(KIND_FREE, 13'($urandom_range(4, 1)),
                 page_addr($urandom_range(span - 1)) + 64'($urandom_range(4095, 1)));
      else if (r < 98) push_cmd(KIND_NONE, 13'($urandom), {$urandom, $urandom});
      else push_cmd(KIND_FREE, 13'(r - 97), 64'(0));
    end
  endtask

  task automatic run_phase(logic [63:0] base, logic [12:0] tot, logic [12:0] klo,
                           logic [12:0] khi, logic [12:0] tlo, logic [12:0] thi,
                           int n, int unsigned max_cnt);
    program_regs(base, tot, klo, khi, tlo, thi);
    gap_pct = (phases % 3 == 0) ? 0 : ((phases % 3 == 1) ? 73 : 33);
    phases++;
    push_cmd(KIND_INIT, '0, '0);
    drain();
    random_cmds(n, max_cnt);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_PAGES; i++) page_used[i] = 1'b1;
    free_cnt = 0;
    map_ready = 1'b0;
    active_pages = 0;
    base_addr = '0;
    {total_reg, kern_lo, kern_hi, tbl_lo, tbl_hi} = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: nothing usable yet
    push_cmd(KIND_ALLOC, 13'd0, '0);
    push_cmd(KIND_ALLOC, 13'd1, '0);
    push_cmd(KIND_FREE, 13'd1, 64'd0);
    push_cmd(KIND_FREE, 13'd1, 64'h1000);
    push_cmd(KIND_INIT, '0, '0);
    push_cmd(KIND_NONE, 13'h1FFF, '1);
    drain();

    // Small map with adjacent reserved ranges: free pages 0,1 and 7..15
    program_regs(64'h8000_0000, 13'd16, 13'd2, 13'd5, 13'd5, 13'd7);
    push_cmd(KIND_ALLOC, 13'd1, '0);
    push_cmd(KIND_INIT, '0, '0);
    push_cmd(KIND_ALLOC, 13'd0, '0);
    push_cmd(KIND_ALLOC, 13'd12, '0);
    push_cmd(KIND_ALLOC, 13'd10, '0);
    push_cmd(KIND_ALLOC, 13'd3, '0);
    push_cmd(KIND_FREE, 13'd1, 64'h7FFF_F000);
    push_cmd(KIND_FREE, 13'd1, 64'h8001_0000);
    push_cmd(KIND_FREE, 13'd1, 64'h8000_8004);
    push_cmd(KIND_FREE, 13'd1, 64'h8000_0000);
    push_cmd(KIND_FREE, 13'h1FFF, 64'h8000_8000);
    push_cmd(KIND_ALLOC, 13'd9, '0);
    push_cmd(KIND_ALLOC, 13'd2, '0);
    push_cmd(KIND_ALLOC, 13'd1, '0);
    push_cmd(KIND_NONE, '0, '0);
    drain();

    // Change the total without init: the latched page count stays in use
    program_regs(64'h8000_0000, 13'd4, 13'd0, 13'd0, 13'd0, 13'd0);
    push_cmd(KIND_FREE, 13'd16, 64'h8000_0000);
    push_cmd(KIND_ALLOC, 13'd11, '0);
    drain();

    // Extremes: full map with wrapping base, oversized total, one page, no pages
    run_phase(64'hFFFF_FFFF_FFFF_0000, 13'd4096, 13'd0, 13'd100, 13'd4000, 13'd4096, 15, 40);
    run_phase(64'h0, 13'h1FFF, 13'd10, 13'd3, 13'h1FFF, 13'd0, 12, 4096);
    run_phase(64'hFFFF_FFFF_FFFF_F000, 13'd1, 13'd1, 13'd1, 13'd0, 13'd0, 30, 2);
    run_phase(64'h0000_1000_0000_0000, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 10, 4);

    // Random settings, mostly small maps
    for (int p = 0; p < 15; p++) begin
      logic [12:0] tot;
      tot = 13'($urandom_range(200, 1));
      run_phase({$urandom, $urandom_range(1) ? 32'($urandom) & 32'hFFFF_F000 : $urandom},
                tot, 13'($urandom_range(tot + 8)), 13'($urandom_range(tot + 8)),
                13'($urandom_range(tot + 8)), 13'($urandom_range(tot + 8)),
                55, $urandom_range(1) ? 6 : 32);
    end
    drain();

    $display("Covered %0d phases, %0d commands taken, %0d results checked",
             phases, cmds_taken, rsps_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Timeout with %0d results still expected", expected_rsps.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
